// ===== sv/irtm_pkg.sv =====
`timescale 1ns / 1ps

package irtm_pkg;

  // Input commands. Codes 6 and 7 carry no meaning and are ignored.
  typedef enum logic [2:0] {
    CMD_LOAD     = 3'd0,
    CMD_BEGIN_WR = 3'd1,
    CMD_BEGIN_RD = 3'd2,
    CMD_ACK      = 3'd3,
    CMD_NACK     = 3'd4,
    CMD_TIMEOUT  = 3'd5
  } cmd_t;

  // Byte-level bus actions on the result channel.
  typedef enum logic [2:0] {
    ACT_START    = 3'd0,
    ACT_RESTART  = 3'd1,
    ACT_STOP     = 3'd2,
    ACT_SEND     = 3'd3,
    ACT_RX_ACK   = 3'd4,
    ACT_RX_NACK  = 3'd5,
    ACT_READ_OUT = 3'd6,
    ACT_DONE     = 3'd7
  } act_t;

  // Failure codes reported with a failed done.
  typedef enum logic [2:0] {
    ERR_NONE      = 3'd0,
    ERR_ADDR_NACK = 3'd1,
    ERR_REG_NACK  = 3'd2,
    ERR_DATA_NACK = 3'd3,
    ERR_RADDR_NACK = 3'd4,
    ERR_TIMEOUT   = 3'd5
  } err_t;

  // Transaction phase.
  typedef enum logic [2:0] {
    PH_IDLE   = 3'd0,
    PH_ADDR_W = 3'd1,
    PH_REG    = 3'd2,
    PH_WDATA  = 3'd3,
    PH_RADDR  = 3'd4,
    PH_RDATA  = 3'd5
  } phase_t;

  // Reset value of the target device address.
  localparam logic [6:0] SLAVE_ADDR_RESET = 7'd104;

  // One result item.
  typedef struct packed {
    act_t        action;
    logic [7:0]  data;
    logic        ok;
    err_t        err;
  } result_t;

  // All results caused by one input item. Slot 0 goes out first.
  // ram_slot0 marks that slot 0 sends the byte read from the write buffer.
  typedef struct packed {
    logic [1:0]    count;
    logic          ram_slot0;
    result_t [2:0] res;
  } plan_t;

  function automatic result_t mk_res(act_t a, logic [7:0] d, logic ok, err_t e);
    result_t r;
    r.action = a;
    r.data   = d;
    r.ok     = ok;
    r.err    = e;
    return r;
  endfunction

endpackage

// ===== sv/irtm_if.sv =====
`timescale 1ns / 1ps

// Input item channel.
interface irtm_in_if;
  logic       valid;
  logic       ready;
  logic [2:0] command;
  logic [7:0] reg_address;
  logic [4:0] byte_count;
  logic [7:0] data_byte;

  modport source (output valid, command, reg_address, byte_count, data_byte, input ready);
  modport sink (input valid, command, reg_address, byte_count, data_byte, output ready);
endinterface

// Result item channel.
interface irtm_out_if;
  logic       valid;
  logic       ready;
  logic [2:0] bus_action;
  logic [7:0] bus_byte;
  logic       done_ok;
  logic [2:0] error_code;
  logic       last;

  modport source (output valid, bus_action, bus_byte, done_ok, error_code, last, input ready);
  modport sink (input valid, bus_action, bus_byte, done_ok, error_code, last, output ready);
endinterface

// Configuration write channel for the target address.
interface irtm_cfg_if;
  logic       valid;
  logic       ready;
  logic [6:0] data;

  modport source (output valid, data, input ready);
  modport sink (input valid, data, output ready);
endinterface

// ===== sv/i2c_register_transaction_master.sv =====
`timescale 1ns / 1ps

// I2C register transaction master. Each input transfer (write-byte load,
// begin write, begin read, or a bus ack, nack or timeout event) yields zero
// to three byte-level bus actions on the result channel, the final one
// flagged with last; a finished transaction always ends in stop and done.
// A new input transfer can be taken every cycle as long as the plan queue
// has room; results leave at one per cycle while the result channel is
// ready, and the first result of an item passes through the staging
// register, the plan queue and the output register.
// The write buffer is a MAX_BURST-byte RAM read once per item. The target
// address resets to 104 and is written through the configuration channel,
// which is always ready; write it only while no transaction is in flight.
module i2c_register_transaction_master import irtm_pkg::*; #(
  parameter int MAX_BURST   = 16,
  parameter int QUEUE_DEPTH = 4
) (
  input  logic       clk,
  input  logic       rst_n,
  irtm_in_if.sink    in_ch,
  irtm_cfg_if.sink   cfg_ch,
  irtm_out_if.source out_ch
);

  logic  push_valid;
  plan_t push_plan;
  logic  q_full;
  logic  q_valid;
  plan_t q_plan;
  logic  q_pop;

  // Sequencer front end.
  irtm_front #(
    .MAX_BURST (MAX_BURST)
  ) u_front (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_ch      (in_ch),
    .cfg_ch     (cfg_ch),
    .push_valid (push_valid),
    .push_plan  (push_plan),
    .q_full     (q_full)
  );

  // Plan queue.
  irtm_queue #(
    .DEPTH (QUEUE_DEPTH)
  ) u_queue (
    .clk        (clk),
    .rst_n      (rst_n),
    .push       (push_valid),
    .push_plan  (push_plan),
    .full       (q_full),
    .pop        (q_pop),
    .head_valid (q_valid),
    .head_plan  (q_plan)
  );

  // Result back end.
  irtm_back u_back (
    .clk     (clk),
    .rst_n   (rst_n),
    .q_valid (q_valid),
    .q_plan  (q_plan),
    .q_pop   (q_pop),
    .out_ch  (out_ch)
  );

endmodule

// ===== sv/irtm_ram.sv =====
`timescale 1ns / 1ps

// Simple dual-port RAM, one write port and one registered read port.
module irtm_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 16
) (
  input  logic                            clk,
  input  logic                            we,
  input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] waddr,
  input  logic [WIDTH-1:0]                wdata,
  input  logic                            re,
  input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] raddr,
  output logic [WIDTH-1:0]                rdata
);

  logic [WIDTH-1:0] mem_r [DEPTH];
  logic [WIDTH-1:0] rdata_r;

  // Write port.
  always_ff @(posedge clk) begin
    if (we) begin
      mem_r[waddr] <= wdata;
    end
  end

  // Registered read; data holds while no read is issued.
  always_ff @(posedge clk) begin
    if (re) begin
      rdata_r <= mem_r[raddr];
    end
  end

  assign rdata = rdata_r;

endmodule

// ===== sv/irtm_front.sv =====
`timescale 1ns / 1ps

// Front end: accepts items, runs the transaction sequencer and turns each
// item into a plan of up to three results for the back end.
module irtm_front import irtm_pkg::*; #(
  parameter int MAX_BURST = 16
) (
  input  logic           clk,
  input  logic           rst_n,
  irtm_in_if.sink        in_ch,
  irtm_cfg_if.sink       cfg_ch,
  output logic           push_valid,
  output plan_t          push_plan,
  input  logic           q_full
);

  localparam int AW  = (MAX_BURST > 1) ? $clog2(MAX_BURST) : 1;
  localparam int LCW = $clog2(MAX_BURST + 1);

  logic [6:0]     slave_address_r;
  phase_t         phase_r, phase_nxt;
  logic           is_read_r, is_read_nxt;
  logic           address_retried_r, address_retried_nxt;
  logic [7:0]     target_register_r, target_register_nxt;
  logic [4:0]     burst_length_r, burst_length_nxt;
  logic [4:0]     byte_index_r, byte_index_nxt;
  logic [LCW-1:0] load_count_r, load_count_nxt;

  logic           sb_valid_r;
  plan_t          sb_plan_r;

  plan_t          plan;
  cmd_t           cmd;
  logic           accept;
  logic           ram_we;
  logic [AW-1:0]  ram_raddr;
  logic [7:0]     ram_rdata;
  logic [4:0]     cnt_adj;
  logic [4:0]     bi_inc;
  logic [7:0]     addr_w;
  logic [7:0]     addr_r;

  // The staging register drains into the queue whenever it has room.
  assign in_ch.ready = !sb_valid_r || !q_full;
  assign accept      = in_ch.valid && in_ch.ready;
  assign cmd         = cmd_t'(in_ch.command);
  assign addr_w      = {slave_address_r, 1'b0};
  assign addr_r      = {slave_address_r, 1'b1};
  assign bi_inc      = byte_index_r + 5'd1;

  // Configuration port: always ready.
  assign cfg_ch.ready = 1'b1;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      slave_address_r <= SLAVE_ADDR_RESET;
    end else if (cfg_ch.valid) begin
      slave_address_r <= cfg_ch.data;
    end
  end

  // Sequencer: next state and the results of the current item.
  always_comb begin
    phase_nxt           = phase_r;
    is_read_nxt         = is_read_r;
    address_retried_nxt = address_retried_r;
    target_register_nxt = target_register_r;
    burst_length_nxt    = burst_length_r;
    byte_index_nxt      = byte_index_r;
    load_count_nxt      = load_count_r;
    plan                = '0;
    ram_we              = 1'b0;
    ram_raddr           = '0;
    cnt_adj             = in_ch.byte_count;

    unique case (cmd)
      CMD_LOAD: begin
        if (phase_r == PH_IDLE && load_count_r < LCW'(MAX_BURST)) begin
          ram_we         = 1'b1;
          load_count_nxt = load_count_r + LCW'(1);
        end
      end
      CMD_BEGIN_WR, CMD_BEGIN_RD: begin
        if (phase_r == PH_IDLE) begin
          is_read_nxt = (cmd == CMD_BEGIN_RD);
          if (cmd == CMD_BEGIN_RD && in_ch.byte_count == 5'd0) begin
            cnt_adj = 5'd1;
          end
          burst_length_nxt    = (int'(cnt_adj) > MAX_BURST) ? 5'(MAX_BURST) : cnt_adj;
          target_register_nxt = in_ch.reg_address;
          address_retried_nxt = 1'b0;
          byte_index_nxt      = 5'd0;
          if (cmd == CMD_BEGIN_WR) begin
            load_count_nxt = '0;
          end
          phase_nxt   = PH_ADDR_W;
          plan.count  = 2'd2;
          plan.res[0] = mk_res(ACT_START, 8'd0, 1'b0, ERR_NONE);
          plan.res[1] = mk_res(ACT_SEND, addr_w, 1'b0, ERR_NONE);
        end
      end
      CMD_ACK: begin
        unique case (phase_r)
          PH_ADDR_W: begin
            phase_nxt   = PH_REG;
            plan.count  = 2'd1;
            plan.res[0] = mk_res(ACT_SEND, target_register_r, 1'b0, ERR_NONE);
          end
          PH_REG: begin
            if (is_read_r) begin
              phase_nxt   = PH_RADDR;
              plan.count  = 2'd2;
              plan.res[0] = mk_res(ACT_RESTART, 8'd0, 1'b0, ERR_NONE);
              plan.res[1] = mk_res(ACT_SEND, addr_r, 1'b0, ERR_NONE);
            end else if (burst_length_r == 5'd0) begin
              phase_nxt   = PH_IDLE;
              plan.count  = 2'd2;
              plan.res[0] = mk_res(ACT_STOP, 8'd0, 1'b0, ERR_NONE);
              plan.res[1] = mk_res(ACT_DONE, 8'd0, 1'b1, ERR_NONE);
            end else begin
              phase_nxt      = PH_WDATA;
              byte_index_nxt = 5'd0;
              plan.count     = 2'd1;
              plan.ram_slot0 = 1'b1;
              plan.res[0]    = mk_res(ACT_SEND, 8'd0, 1'b0, ERR_NONE);
              ram_raddr      = '0;
            end
          end
          PH_WDATA: begin
            byte_index_nxt = bi_inc;
            if (bi_inc >= burst_length_r) begin
              phase_nxt   = PH_IDLE;
              plan.count  = 2'd2;
              plan.res[0] = mk_res(ACT_STOP, 8'd0, 1'b0, ERR_NONE);
              plan.res[1] = mk_res(ACT_DONE, 8'd0, 1'b1, ERR_NONE);
            end else begin
              plan.count     = 2'd1;
              plan.ram_slot0 = 1'b1;
              plan.res[0]    = mk_res(ACT_SEND, 8'd0, 1'b0, ERR_NONE);
              ram_raddr      = AW'(bi_inc);
            end
          end
          PH_RADDR: begin
            phase_nxt      = PH_RDATA;
            byte_index_nxt = 5'd0;
            plan.count     = 2'd1;
            plan.res[0]    = mk_res((burst_length_r <= 5'd1) ? ACT_RX_NACK : ACT_RX_ACK,
                                    8'd0, 1'b0, ERR_NONE);
          end
          PH_RDATA: begin
            plan.res[0]    = mk_res(ACT_READ_OUT, in_ch.data_byte, 1'b0, ERR_NONE);
            byte_index_nxt = bi_inc;
            if (bi_inc >= burst_length_r) begin
              phase_nxt   = PH_IDLE;
              plan.count  = 2'd3;
              plan.res[1] = mk_res(ACT_STOP, 8'd0, 1'b0, ERR_NONE);
              plan.res[2] = mk_res(ACT_DONE, 8'd0, 1'b1, ERR_NONE);
            end else begin
              plan.count  = 2'd2;
              plan.res[1] = mk_res(({1'b0, bi_inc} + 6'd1 >= {1'b0, burst_length_r}) ?
                                   ACT_RX_NACK : ACT_RX_ACK, 8'd0, 1'b0, ERR_NONE);
            end
          end
          default: begin
          end
        endcase
      end
      CMD_NACK: begin
        if (phase_r == PH_ADDR_W && !address_retried_r) begin
          // The first address nack gets one stop/start retry.
          address_retried_nxt = 1'b1;
          plan.count  = 2'd3;
          plan.res[0] = mk_res(ACT_STOP, 8'd0, 1'b0, ERR_NONE);
          plan.res[1] = mk_res(ACT_START, 8'd0, 1'b0, ERR_NONE);
          plan.res[2] = mk_res(ACT_SEND, addr_w, 1'b0, ERR_NONE);
        end else if (phase_r == PH_ADDR_W || phase_r == PH_REG ||
                     phase_r == PH_WDATA || phase_r == PH_RADDR) begin
          phase_nxt   = PH_IDLE;
          plan.count  = 2'd2;
          plan.res[0] = mk_res(ACT_STOP, 8'd0, 1'b0, ERR_NONE);
          unique case (phase_r)
            PH_ADDR_W: plan.res[1] = mk_res(ACT_DONE, 8'd0, 1'b0, ERR_ADDR_NACK);
            PH_REG:    plan.res[1] = mk_res(ACT_DONE, 8'd0, 1'b0, ERR_REG_NACK);
            PH_WDATA:  plan.res[1] = mk_res(ACT_DONE, 8'd0, 1'b0, ERR_DATA_NACK);
            default:   plan.res[1] = mk_res(ACT_DONE, 8'd0, 1'b0, ERR_RADDR_NACK);
          endcase
        end
      end
      CMD_TIMEOUT: begin
        if (phase_r != PH_IDLE) begin
          phase_nxt   = PH_IDLE;
          plan.count  = 2'd2;
          plan.res[0] = mk_res(ACT_STOP, 8'd0, 1'b0, ERR_NONE);
          plan.res[1] = mk_res(ACT_DONE, 8'd0, 1'b0, ERR_TIMEOUT);
        end
      end
      default: begin
      end
    endcase
  end

  // Sequencer state.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      phase_r           <= PH_IDLE;
      is_read_r         <= 1'b0;
      address_retried_r <= 1'b0;
      target_register_r <= 8'd0;
      burst_length_r    <= 5'd0;
      byte_index_r      <= 5'd0;
      load_count_r      <= '0;
    end else if (accept) begin
      phase_r           <= phase_nxt;
      is_read_r         <= is_read_nxt;
      address_retried_r <= address_retried_nxt;
      target_register_r <= target_register_nxt;
      burst_length_r    <= burst_length_nxt;
      byte_index_r      <= byte_index_nxt;
      load_count_r      <= load_count_nxt;
    end
  end

  // Write buffer. The byte for a data send is read on the accepting edge
  // and is ready when the plan leaves the staging register.
  irtm_ram #(
    .WIDTH (8),
    .DEPTH (MAX_BURST)
  ) u_wbuf (
    .clk   (clk),
    .we    (accept && ram_we),
    .waddr (load_count_r[AW-1:0]),
    .wdata (in_ch.data_byte),
    .re    (accept),
    .raddr (ram_raddr),
    .rdata (ram_rdata)
  );

  // Staging register between the sequencer and the queue.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      sb_valid_r <= 1'b0;
    end else if (accept) begin
      sb_valid_r <= (plan.count != 2'd0);
    end else if (!q_full) begin
      sb_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      sb_plan_r <= plan;
    end
  end

  // Merge the buffer byte into the first slot on its way to the queue.
  always_comb begin
    push_plan = sb_plan_r;
    if (sb_plan_r.ram_slot0) begin
      push_plan.res[0].data = ram_rdata;
    end
  end

  assign push_valid = sb_valid_r && !q_full;

  // A staged plan always has at least one result.
  a_sb_nonempty: assert property (@(posedge clk) disable iff (!rst_n)
    sb_valid_r |-> sb_plan_r.count != 2'd0)
    else $error("staged plan without results");

  // The load counter never passes the buffer depth.
  a_load_bound: assert property (@(posedge clk) disable iff (!rst_n)
    load_count_r <= LCW'(MAX_BURST))
    else $error("load count beyond buffer depth");

  // While moving data the index stays inside the burst.
  a_index_bound: assert property (@(posedge clk) disable iff (!rst_n)
    (phase_r == PH_WDATA || phase_r == PH_RDATA) |-> byte_index_r < burst_length_r)
    else $error("byte index outside the burst");

  // Receiving data only happens in a read transaction.
  a_rdata_is_read: assert property (@(posedge clk) disable iff (!rst_n)
    phase_r == PH_RDATA |-> is_read_r)
    else $error("receive phase in a write transaction");

endmodule

// ===== sv/irtm_queue.sv =====
`timescale 1ns / 1ps

// Short plan queue between front and back end.
module irtm_queue import irtm_pkg::*; #(
  parameter int DEPTH = 4
) (
  input  logic  clk,
  input  logic  rst_n,
  input  logic  push,
  input  plan_t push_plan,
  output logic  full,
  input  logic  pop,
  output logic  head_valid,
  output plan_t head_plan
);

  localparam int PW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int CW = $clog2(DEPTH + 1);

  plan_t           mem_r [DEPTH];
  logic [PW-1:0]   wr_ptr_r;
  logic [PW-1:0]   rd_ptr_r;
  logic [CW-1:0]   cnt_r;
  logic            do_pop;

  assign full       = (cnt_r == CW'(DEPTH));
  assign head_valid = (cnt_r != '0);
  assign head_plan  = mem_r[rd_ptr_r];
  assign do_pop     = pop && head_valid;

  // Storage.
  always_ff @(posedge clk) begin
    if (push) begin
      mem_r[wr_ptr_r] <= push_plan;
    end
  end

  // Pointers and fill count.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      cnt_r    <= '0;
    end else begin
      if (push) begin
        wr_ptr_r <= (wr_ptr_r == PW'(DEPTH - 1)) ? '0 : wr_ptr_r + PW'(1);
      end
      if (do_pop) begin
        rd_ptr_r <= (rd_ptr_r == PW'(DEPTH - 1)) ? '0 : rd_ptr_r + PW'(1);
      end
      if (push && !do_pop) begin
        cnt_r <= cnt_r + CW'(1);
      end else if (!push && do_pop) begin
        cnt_r <= cnt_r - CW'(1);
      end
    end
  end

endmodule

// ===== sv/irtm_back.sv =====
`timescale 1ns / 1ps

// Back end: walks the slots of the plan at the queue head and sends one
// result per cycle through the output register while the result channel is ready.
module irtm_back import irtm_pkg::*; (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        q_valid,
  input  plan_t       q_plan,
  output logic        q_pop,
  irtm_out_if.source  out_ch
);

  logic [1:0] slot_r;
  logic       out_valid_r;
  result_t    out_res_r;
  logic       out_last_r;
  logic       load;
  logic       slot_last;

  assign load      = q_valid && (!out_valid_r || out_ch.ready);
  assign slot_last = (slot_r == q_plan.count - 2'd1);
  assign q_pop     = load && slot_last;

  // Slot counter and output valid.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      slot_r      <= 2'd0;
      out_valid_r <= 1'b0;
    end else begin
      if (load) begin
        slot_r <= slot_last ? 2'd0 : slot_r + 2'd1;
      end
      if (load) begin
        out_valid_r <= 1'b1;
      end else if (out_ch.ready) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  // Output payload register.
  always_ff @(posedge clk) begin
    if (load) begin
      out_res_r  <= q_plan.res[slot_r];
      out_last_r <= slot_last;
    end
  end

  assign out_ch.valid      = out_valid_r;
  assign out_ch.bus_action = out_res_r.action;
  assign out_ch.bus_byte   = out_res_r.data;
  assign out_ch.done_ok    = out_res_r.ok;
  assign out_ch.error_code = out_res_r.err;
  assign out_ch.last       = out_last_r;

  // The slot pointer stays inside the plan at the head.
  a_slot_in_plan: assert property (@(posedge clk) disable iff (!rst_n)
    q_valid |-> slot_r < q_plan.count)
    else $error("slot beyond plan length");

  // A partly sent plan is never dropped from the head.
  a_partial_kept: assert property (@(posedge clk) disable iff (!rst_n)
    slot_r != 2'd0 |-> q_valid)
    else $error("partly sent plan vanished");

endmodule

// ===== dv/irtm_bus_action_checker.sv =====
`timescale 1ns / 1ps

// Watches the input, configuration and result channels of the transaction
// master, predicts the bus actions that every accepted input transfer causes
// and compares each result transfer against the oldest prediction.
module irtm_bus_action_checker import irtm_pkg::*; #(
  parameter int MAX_BURST = 16
) (
  input  logic clk,
  input  logic rst_n,
  irtm_in_if   in_ch,
  irtm_cfg_if  cfg_ch,
  irtm_out_if  out_ch,
  output int   fail_count,
  output int   pending
);

  typedef struct {
    act_t       action;
    logic [7:0] data;
    logic       ok;
    err_t       err;
    logic       last;
  } bus_step_t;

  bus_step_t expected_actions[$];

  // Mirror of the sequencer state.
  logic [6:0] target_addr;
  phase_t     phase;
  logic       reading;
  logic       retried;
  logic [7:0] target_reg;
  logic [4:0] burst_len;
  logic [4:0] byte_idx;
  logic [4:0] load_cnt;
  logic [7:0] write_buf [MAX_BURST];
  int         errors;

  function automatic void push_step(act_t a, logic [7:0] d, logic ok, err_t e);
    bus_step_t s;
    s.action = a;
    s.data   = d;
    s.ok     = ok;
    s.err    = e;
    s.last   = 1'b0;
    expected_actions.push_back(s);
  endfunction

  // Every finished transaction closes with stop and done.
  function automatic void end_transaction(logic ok, err_t e);
    push_step(ACT_STOP, 8'd0, 1'b0, ERR_NONE);
    push_step(ACT_DONE, 8'd0, ok, ok ? ERR_NONE : e);
    phase = PH_IDLE;
  endfunction

  function automatic void predict_bus_actions(logic [2:0] cmd, logic [7:0] rega,
                                              logic [4:0] cnt, logic [7:0] dat);
    int         prior_size;
    int         len;
    logic [7:0] addr_w;
    bus_step_t  tail;
    prior_size = expected_actions.size();
    addr_w = {target_addr, 1'b0};
    case (cmd)
      CMD_LOAD: begin
        if (phase == PH_IDLE && load_cnt < MAX_BURST) begin
          write_buf[load_cnt] = dat;
          load_cnt = load_cnt + 5'd1;
        end
      end
      CMD_BEGIN_WR, CMD_BEGIN_RD: begin
        if (phase == PH_IDLE) begin
          reading = (cmd == CMD_BEGIN_RD);
          len = cnt;
          if (reading && len == 0) len = 1;
          if (len > MAX_BURST) len = MAX_BURST;
          burst_len  = len[4:0];
          target_reg = rega;
          retried    = 1'b0;
          byte_idx   = 5'd0;
          if (!reading) load_cnt = 5'd0;
          phase = PH_ADDR_W;
          push_step(ACT_START, 8'd0, 1'b0, ERR_NONE);
          push_step(ACT_SEND, addr_w, 1'b0, ERR_NONE);
        end
      end
      CMD_ACK: begin
        case (phase)
          PH_ADDR_W: begin
            phase = PH_REG;
            push_step(ACT_SEND, target_reg, 1'b0, ERR_NONE);
          end
          PH_REG: begin
            if (reading) begin
              phase = PH_RADDR;
              push_step(ACT_RESTART, 8'd0, 1'b0, ERR_NONE);
              push_step(ACT_SEND, addr_w | 8'd1, 1'b0, ERR_NONE);
            end else if (burst_len == 0) begin
              end_transaction(1'b1, ERR_NONE);
            end else begin
              phase = PH_WDATA;
              byte_idx = 5'd0;
              push_step(ACT_SEND, write_buf[0], 1'b0, ERR_NONE);
            end
          end
          PH_WDATA: begin
            byte_idx = byte_idx + 5'd1;
            if (byte_idx >= burst_len) end_transaction(1'b1, ERR_NONE);
            else push_step(ACT_SEND, write_buf[byte_idx], 1'b0, ERR_NONE);
          end
          PH_RADDR: begin
            phase = PH_RDATA;
            byte_idx = 5'd0;
            push_step((burst_len <= 1) ? ACT_RX_NACK : ACT_RX_ACK, 8'd0, 1'b0, ERR_NONE);
          end
          PH_RDATA: begin
            push_step(ACT_READ_OUT, dat, 1'b0, ERR_NONE);
            byte_idx = byte_idx + 5'd1;
            if (byte_idx >= burst_len) end_transaction(1'b1, ERR_NONE);
            else push_step((byte_idx + 5'd1 >= burst_len) ? ACT_RX_NACK : ACT_RX_ACK,
                           8'd0, 1'b0, ERR_NONE);
          end
          default: ;
        endcase
      end
      CMD_NACK: begin
        case (phase)
          PH_ADDR_W: begin
            // The first address nack of a transaction gets one retry.
            if (!retried) begin
              retried = 1'b1;
              push_step(ACT_STOP, 8'd0, 1'b0, ERR_NONE);
              push_step(ACT_START, 8'd0, 1'b0, ERR_NONE);
              push_step(ACT_SEND, addr_w, 1'b0, ERR_NONE);
            end else begin
              end_transaction(1'b0, ERR_ADDR_NACK);
            end
          end
          PH_REG:   end_transaction(1'b0, ERR_REG_NACK);
          PH_WDATA: end_transaction(1'b0, ERR_DATA_NACK);
          PH_RADDR: end_transaction(1'b0, ERR_RADDR_NACK);
          default: ;
        endcase
      end
      CMD_TIMEOUT: begin
        if (phase != PH_IDLE) end_transaction(1'b0, ERR_TIMEOUT);
      end
      default: ;
    endcase
    // Flag the final result of this transfer.
    if (expected_actions.size() > prior_size) begin
      tail = expected_actions.pop_back();
      tail.last = 1'b1;
      expected_actions.push_back(tail);
    end
  endfunction

  task automatic compare_field(input string name, input int want, input int got);
    if (want != got) begin
      $error("%s: expected %0d, got %0d", name, want, got);
      errors++;
    end
  endtask

  always @(posedge clk) begin
    bus_step_t want;
    if (!rst_n) begin
      target_addr = SLAVE_ADDR_RESET;
      phase       = PH_IDLE;
      reading     = 1'b0;
      retried     = 1'b0;
      target_reg  = 8'd0;
      burst_len   = 5'd0;
      byte_idx    = 5'd0;
      load_cnt    = 5'd0;
      errors      = 0;
      expected_actions.delete();
    end else begin
      // Results first: a result in this cycle cannot stem from an input of this cycle.
      if (out_ch.valid && out_ch.ready) begin
        if (expected_actions.size() == 0) begin
          $error("result transfer with no expectation waiting: bus_action %0d",
                 out_ch.bus_action);
          errors++;
        end else begin
          want = expected_actions.pop_front();
          compare_field("bus_action", want.action, out_ch.bus_action);
          compare_field("bus_byte", want.data, out_ch.bus_byte);
          compare_field("done_ok", want.ok, out_ch.done_ok);
          compare_field("error_code", want.err, out_ch.error_code);
          compare_field("last", want.last, out_ch.last);
        end
      end
      if (cfg_ch.valid && cfg_ch.ready) target_addr = cfg_ch.data;
      if (in_ch.valid && in_ch.ready)
        predict_bus_actions(in_ch.command, in_ch.reg_address, in_ch.byte_count,
                            in_ch.data_byte);
    end
    fail_count <= errors;
    pending    <= expected_actions.size();
  end

endmodule

// ===== dv/i2c_register_transaction_master_tb.sv =====
`timescale 1ns / 1ps

module i2c_register_transaction_master_tb;
  import irtm_pkg::*;

  // Command codes that the block ignores.
  localparam logic [2:0] CMD_SPARE_6 = 3'd6;
  localparam logic [2:0] CMD_SPARE_7 = 3'd7;

  localparam int MAX_BURST    = 16;
  localparam int CYCLE_LIMIT  = 300000;
  localparam int LONG_HOLD    = 120;
  localparam int RANDOM_ITEMS = 470;
  localparam int PHASES       = 5;

  logic clk = 1'b0;
  logic rst_n;
  logic steady;
  int   stall_requests;
  int   items_offered = 0;
  int   cycles = 0;
  int   check_fails;
  int   check_pending;

  irtm_in_if  in_if ();
  irtm_out_if out_if ();
  irtm_cfg_if cfg_if ();

  i2c_register_transaction_master i_dut (
    .clk    (clk),
    .rst_n  (rst_n),
    .in_ch  (in_if),
    .cfg_ch (cfg_if),
    .out_ch (out_if)
  );

  irtm_bus_action_checker #(.MAX_BURST(MAX_BURST)) i_checker (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_ch      (in_if),
    .cfg_ch     (cfg_if),
    .out_ch     (out_if),
    .fail_count (check_fails),
    .pending    (check_pending)
  );

  always #5 clk = ~clk;

  // Watchdog on the whole run.
  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (cycles >= CYCLE_LIMIT) begin
      $display("i2c_register_transaction_master test failed");
      $finish;
    end
  end

  // Offer one input item after a random gap and wait for its transfer.
  task automatic offer(input logic [2:0] cmd, input logic [7:0] rega,
                       input logic [4:0] cnt, input logic [7:0] dat);
    int gap;
    gap = steady ? 0 : $urandom_range(0, 6);
    if (gap > 0) begin
      in_if.valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_if.valid       <= 1'b1;
    in_if.command     <= cmd;
    in_if.reg_address <= rega;
    in_if.byte_count  <= cnt;
    in_if.data_byte   <= dat;
    @(posedge clk);
    while (!in_if.ready) @(posedge clk);
    items_offered++;
  endtask

  // Stop offering until every expected result has arrived, then let the
  // pipeline run dry.
  task automatic settle();
    in_if.valid <= 1'b0;
    @(posedge clk);
    while (check_pending != 0) @(posedge clk);
    repeat (6) @(posedge clk);
  endtask

  // A timeout ends any transaction still open, so the block is idle after this.
  task automatic quiesce();
    offer(CMD_TIMEOUT, 8'($urandom), 5'($urandom_range(0, MAX_BURST)), 8'($urandom));
    settle();
  endtask

  // Result side: random hold-offs, plus one long hold when asked for.
  initial begin
    int hold;
    int stalls_seen;
    out_if.ready = 1'b0;
    stalls_seen  = 0;
    while (rst_n !== 1'b1) @(posedge clk);
    forever begin
      hold = steady ? 0 : $urandom_range(0, 6);
      if (stall_requests != stalls_seen) begin
        stalls_seen = stall_requests;
        hold = LONG_HOLD;
      end
      if (hold > 0) begin
        out_if.ready <= 1'b0;
        repeat (hold) @(posedge clk);
      end
      out_if.ready <= 1'b1;
      @(posedge clk);
      while (!(out_if.valid && out_if.ready)) @(posedge clk);
    end
  end

  initial begin
    int   target;
    int   loads;
    int   steps;
    int   n;
    int   roll;
    logic rd;
    logic stall_issued;
    logic aborted;

    in_if.valid       = 1'b0;
    in_if.command     = CMD_LOAD;
    in_if.reg_address = 8'd0;
    in_if.byte_count  = 5'd0;
    in_if.data_byte   = 8'd0;
    cfg_if.valid      = 1'b0;
    cfg_if.data       = 7'd0;
    steady            = 1'b0;
    stall_requests    = 0;
    stall_issued      = 1'b0;
    rst_n             = 1'b0;
    repeat (6) @(posedge clk);
    rst_n <= 1'b1;

    // Fill every buffer entry, then one more load that the full buffer drops.
    for (int i = 0; i <= MAX_BURST; i++)
      offer(CMD_LOAD, 8'h00, 5'd0, (i == 0) ? 8'h00 : (i == 1) ? 8'hFF : 8'($urandom));

    // Bus events and spare codes while idle.
    offer(CMD_ACK, 8'hFF, 5'd16, 8'hFF);
    offer(CMD_NACK, 8'h00, 5'd0, 8'h00);
    offer(CMD_SPARE_6, 8'h12, 5'd3, 8'h34);
    offer(CMD_SPARE_7, 8'hFF, 5'd16, 8'hFF);

    // Zero-byte write: the register byte goes straight to stop and done.
    offer(CMD_BEGIN_WR, 8'hFF, 5'd0, 8'h00);
    offer(CMD_ACK, 8'h00, 5'd0, 8'h00);
    offer(CMD_ACK, 8'h00, 5'd0, 8'h00);

    // Zero-length read, address nacked twice: retry, then failure.
    offer(CMD_BEGIN_RD, 8'h00, 5'd0, 8'h00);
    offer(CMD_NACK, 8'h00, 5'd0, 8'h00);
    offer(CMD_NACK, 8'h00, 5'd0, 8'h00);

    // Read address nack after the repeated start.
    offer(CMD_BEGIN_RD, 8'hA5, 5'd1, 8'h00);
    offer(CMD_ACK, 8'h00, 5'd0, 8'h00);
    offer(CMD_ACK, 8'h00, 5'd0, 8'h00);
    offer(CMD_NACK, 8'h00, 5'd0, 8'h00);

    // Register nack, then data nack on a write.
    offer(CMD_BEGIN_WR, 8'h5A, 5'd1, 8'h00);
    offer(CMD_ACK, 8'h00, 5'd0, 8'h00);
    offer(CMD_NACK, 8'h00, 5'd0, 8'h00);
    offer(CMD_BEGIN_WR, 8'h3C, 5'd2, 8'h00);
    offer(CMD_ACK, 8'h00, 5'd0, 8'h00);
    offer(CMD_ACK, 8'h00, 5'd0, 8'h00);
    offer(CMD_NACK, 8'h00, 5'd0, 8'h00);

    // Two-byte read with a begin and a load while busy and a nack while receiving.
    offer(CMD_BEGIN_RD, 8'hC3, 5'd2, 8'h00);
    offer(CMD_BEGIN_WR, 8'h11, 5'd4, 8'h00);
    offer(CMD_ACK, 8'h00, 5'd0, 8'h00);
    offer(CMD_LOAD, 8'h00, 5'd0, 8'hAA);
    offer(CMD_ACK, 8'h00, 5'd0, 8'h00);
    offer(CMD_ACK, 8'h00, 5'd0, 8'h00);
    offer(CMD_NACK, 8'h00, 5'd0, 8'h00);
    offer(CMD_ACK, 8'h00, 5'd0, 8'h00);
    offer(CMD_ACK, 8'h00, 5'd0, 8'hFF);

    // Timeout in the middle of a write.
    offer(CMD_BEGIN_WR, 8'h80, 5'd3, 8'h00);
    offer(CMD_TIMEOUT, 8'h00, 5'd0, 8'h00);

    // Random phases, each under its own target address.
    for (int p = 0; p < PHASES; p++) begin
      quiesce();
      cfg_if.valid <= 1'b1;
      case (p)
        0:          cfg_if.data <= 7'd0;
        1:          cfg_if.data <= 7'h7F;
        PHASES - 1: cfg_if.data <= SLAVE_ADDR_RESET;
        default:    cfg_if.data <= 7'($urandom_range(1, 126));
      endcase
      @(posedge clk);
      while (!cfg_if.ready) @(posedge clk);
      cfg_if.valid <= 1'b0;
      steady <= (p == 3);
      target = items_offered + RANDOM_ITEMS / PHASES;

      while (items_offered < target) begin
        // Once, hold the result side off long enough for the block to back up.
        if (p == 2 && !stall_issued && items_offered > target - 60) begin
          stall_requests <= stall_requests + 1;
          stall_issued = 1'b1;
        end

        // One well-formed transaction with random content and injected faults.
        rd = $urandom_range(0, 1);
        roll = $urandom_range(0, 19);
        if (roll < 14) n = $urandom_range(0, 4);
        else if (roll < 19) n = $urandom_range(5, 15);
        else n = MAX_BURST;
        if (!rd) begin
          loads = n + (($urandom_range(0, 4) == 0) ? 2 : 0);
          for (int i = 0; i < loads; i++)
            offer(CMD_LOAD, 8'($urandom), 5'($urandom_range(0, MAX_BURST)), 8'($urandom));
        end
        offer(rd ? CMD_BEGIN_RD : CMD_BEGIN_WR, 8'($urandom), 5'(n), 8'($urandom));
        steps = rd ? 3 + ((n == 0) ? 1 : n) : 2 + n;
        aborted = 1'b0;
        for (int i = 0; i < steps && !aborted; i++) begin
          roll = $urandom_range(0, 99);
          if (roll < 3) begin
            offer(CMD_TIMEOUT, 8'($urandom), 5'($urandom_range(0, MAX_BURST)),
                  8'($urandom));
            aborted = 1'b1;
          end else begin
            if (roll < 11)
              offer(CMD_NACK, 8'($urandom), 5'($urandom_range(0, MAX_BURST)),
                    8'($urandom));
            else if (roll < 13)
              offer(3'($urandom_range(CMD_LOAD, CMD_SPARE_7)), 8'($urandom),
                    5'($urandom_range(0, MAX_BURST)), 8'($urandom));
            offer(CMD_ACK, 8'($urandom), 5'($urandom_range(0, MAX_BURST)), 8'($urandom));
          end
        end

        // Occasional noise between transactions.
        if ($urandom_range(0, 9) == 0) begin
          for (int i = 0; i < $urandom_range(1, 3); i++)
            offer(3'($urandom_range(CMD_LOAD, CMD_SPARE_7)), 8'($urandom),
                  5'($urandom_range(0, MAX_BURST)), 8'($urandom));
        end

        // Now and then the sender waits for every result to come back.
        if ($urandom_range(0, 49) == 0) settle();
      end
    end

    quiesce();
    repeat (10) @(posedge clk);
    if (check_fails == 0 && check_pending == 0) begin
      $display("i2c_register_transaction_master test passed");
    end else begin
      $display("i2c_register_transaction_master test failed");
    end
    $finish;
  end

endmodule
